FILE: rtl/fwpi_pkg.sv
// shared types, register codes and constants for the four-wheel pi speed controller
package fwpi_pkg;

  localparam int NUM_LANES = 4;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;

  // lane order: rear left, rear right, front left, front right
  localparam int LANE_RL = 0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_RL = 8'd0,
    REG_KP_RR = 8'd1,
    REG_KP_FL = 8'd2,
    REG_KP_FR = 8'd3,
    REG_KI    = 8'd4,
    REG_KD_RL = 8'd5,
    REG_ILIM  = 8'd6,
    REG_PLIM  = 8'd7
  } reg_idx_t;

  localparam logic [15:0] RST_KP_RL = 16'd896;
  localparam logic [15:0] RST_KP_RR = 16'd896;
  localparam logic [15:0] RST_KP_FL = 16'd768;
  localparam logic [15:0] RST_KP_FR = 16'd691;
  localparam logic [15:0] RST_KI    = 16'd3277;
  localparam logic [15:0] RST_KD_RL = 16'd0;
  localparam logic [14:0] RST_ILIM  = 15'd800;
  localparam logic [14:0] RST_PLIM  = 15'd5000;

  // error multiplier and front-axle flag per lane
  localparam logic [2:0] ERR_MULT [NUM_LANES] = '{3'd5, 3'd4, 3'd3, 3'd2};
  localparam logic LANE_FRONT [NUM_LANES] = '{1'b0, 1'b0, 1'b1, 1'b1};

  typedef struct packed {
    logic [15:0] kp_rl;
    logic [15:0] kp_rr;
    logic [15:0] kp_fl;
    logic [15:0] kp_fr;
    logic [15:0] ki;
    logic [15:0] kd_rl;
    logic [14:0] ilim;
    logic [14:0] plim;
  } cfg_t;

  // per-stage load strobes and the loop-state update strobe, shared by all lanes
  typedef struct packed {
    logic ld_a;
    logic ld_b;
    logic ld_c;
    logic ld_d;
    logic upd;
  } lane_ctrl_t;

endpackage

FILE: rtl/four_wheel_pi_speed_control_core.sv
// top level of the four-wheel pi speed controller: lanes, pipeline control, output merge
//
//  channel  signals                          direction  moves
//  in       in_valid / in_stall + fields     into core  one control tick request
//  out      out_valid / out_stall + fields   out        duty and direction, four wheels
//  cfg      cfg_valid / cfg_ready            into core  one register write
//
// one request per clock sustained while out_stall is low; the integrator add-and-clamp
// and last-error difference in stage c are the loops behind it; the rest is feed-forward
// a request moves through stage registers a, b, c and d, then the output register
// reset (rst, synchronous) clears valids, integrators, last error and config to defaults
// out_stall holds the output register; stages behind it keep filling until full,
// then in_stall rises
module four_wheel_pi_speed_control_core (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            run,
  input  logic signed [15:0]              target_rear_left,
  input  logic signed [15:0]              target_rear_right,
  input  logic signed [15:0]              target_front_left,
  input  logic signed [15:0]              target_front_right,
  input  logic signed [15:0]              enc_rear_left,
  input  logic signed [15:0]              enc_rear_right,
  input  logic signed [15:0]              enc_front_left,
  input  logic signed [15:0]              enc_front_right,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [14:0]                     duty_rear_left,
  output logic                            dir_rear_left,
  output logic [14:0]                     duty_rear_right,
  output logic                            dir_rear_right,
  output logic [14:0]                     duty_front_left,
  output logic                            dir_front_left,
  output logic [14:0]                     duty_front_right,
  output logic                            dir_front_right,
  // config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fwpi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fwpi_pkg::CFG_DATA_W-1:0] cfg_data
);

  fwpi_pkg::cfg_t       cfg;
  fwpi_pkg::lane_ctrl_t ctrl;

  // stage valids and the run flag that travels beside each stage
  logic va, vb, vc, vd;
  logic run_a, run_b, run_c, run_d;
  logic rdy_b, rdy_c, rdy_d, rdy_e;
  logic ld_e;

  logic signed [15:0] tgt   [fwpi_pkg::NUM_LANES];
  logic signed [15:0] encs  [fwpi_pkg::NUM_LANES];
  logic [15:0]        kps   [fwpi_pkg::NUM_LANES];
  logic signed [15:0] drive [fwpi_pkg::NUM_LANES];
  logic [14:0]        duty_next [fwpi_pkg::NUM_LANES];
  logic               dir_next  [fwpi_pkg::NUM_LANES];
  logic [14:0]        duty [fwpi_pkg::NUM_LANES];
  logic               dir  [fwpi_pkg::NUM_LANES];
  logic signed [15:0] neg_drive [fwpi_pkg::NUM_LANES];

  // config writes are always taken
  assign cfg_ready = 1'b1;

  fwpi_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr    (cfg_valid && cfg_ready),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // a stage can take a new request when empty or when its contents move on
  assign rdy_e    = !out_valid || !out_stall;
  assign rdy_d    = !vd || rdy_e;
  assign rdy_c    = !vc || rdy_d;
  assign rdy_b    = !vb || rdy_c;
  assign in_stall = va && !rdy_b;

  assign ctrl.ld_a = in_valid && !in_stall;
  assign ctrl.ld_b = va && rdy_b;
  assign ctrl.ld_c = vb && rdy_c;
  assign ctrl.ld_d = vc && rdy_d;
  // loop state moves only when a running request passes stage c
  assign ctrl.upd  = ctrl.ld_c && run_b;
  assign ld_e      = vd && rdy_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va        <= ctrl.ld_a || (va && !rdy_b);
      vb        <= ctrl.ld_b || (vb && !rdy_c);
      vc        <= ctrl.ld_c || (vc && !rdy_d);
      vd        <= ctrl.ld_d || (vd && !rdy_e);
      out_valid <= ld_e || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_a) begin
      run_a <= run;
    end
    if (ctrl.ld_b) begin
      run_b <= run_a;
    end
    if (ctrl.ld_c) begin
      run_c <= run_b;
    end
    if (ctrl.ld_d) begin
      run_d <= run_c;
    end
  end

  // wheel order fixed by the package: rear left, rear right, front left, front right
  assign tgt[0]  = target_rear_left;
  assign tgt[1]  = target_rear_right;
  assign tgt[2]  = target_front_left;
  assign tgt[3]  = target_front_right;
  assign encs[0] = enc_rear_left;
  assign encs[1] = enc_rear_right;
  assign encs[2] = enc_front_left;
  assign encs[3] = enc_front_right;
  assign kps[0]  = cfg.kp_rl;
  assign kps[1]  = cfg.kp_rr;
  assign kps[2]  = cfg.kp_fl;
  assign kps[3]  = cfg.kp_fr;

  for (genvar i = 0; i < fwpi_pkg::NUM_LANES; i++) begin : g_lane
    // only rear left carries a derivative term
    fwpi_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .err_mult (fwpi_pkg::ERR_MULT[i]),
      .kp       (kps[i]),
      .kd       ((i == fwpi_pkg::LANE_RL) ? cfg.kd_rl : 16'd0),
      .ki       (cfg.ki),
      .ilim     (cfg.ilim),
      .plim     (cfg.plim),
      .target   (tgt[i]),
      .enc      (encs[i]),
      .drive    (drive[i])
    );
  end

  // merge: sign split per wheel; stopped ticks read as zero drive
  always_comb begin
    for (int i = 0; i < fwpi_pkg::NUM_LANES; i++) begin
      neg_drive[i] = -drive[i];
      if (run_d && (drive[i] > 16'sd0)) begin
        duty_next[i] = drive[i][14:0];
        dir_next[i]  = fwpi_pkg::LANE_FRONT[i];
      end else begin
        duty_next[i] = run_d ? neg_drive[i][14:0] : 15'd0;
        dir_next[i]  = !fwpi_pkg::LANE_FRONT[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_e) begin
      for (int i = 0; i < fwpi_pkg::NUM_LANES; i++) begin
        duty[i] <= duty_next[i];
        dir[i]  <= dir_next[i];
      end
    end
  end

  assign duty_rear_left   = duty[0];
  assign dir_rear_left    = dir[0];
  assign duty_rear_right  = duty[1];
  assign dir_rear_right   = dir[1];
  assign duty_front_left  = duty[2];
  assign dir_front_left   = dir[2];
  assign duty_front_right = duty[3];
  assign dir_front_right  = dir[3];

`ifndef SYNTH
  // a forward front left direction always comes with a nonzero duty
  a_front_dir_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid && dir_front_left |-> duty_front_left != 15'd0)
    else $error("front left forward with zero duty");

  // a forward rear left direction always comes with a nonzero duty
  a_rear_dir_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !dir_rear_left |-> duty_rear_left != 15'd0)
    else $error("rear left forward with zero duty");

  // rear right and front right duty never exceed the pwm limit
  a_duty_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (duty_rear_right <= cfg.plim) && (duty_front_right <= cfg.plim))
    else $error("duty above pwm limit");

  // a request taken at the input is held in stage a on the next cycle
  a_stage_a_fill: assert property (@(posedge clk) disable iff (rst)
    ctrl.ld_a |=> va)
    else $error("accepted request lost at stage a");
`endif

endmodule

FILE: rtl/fwpi_cfg_regs.sv
// configuration register file for the four-wheel pi speed controller
module fwpi_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr,
  input  logic [fwpi_pkg::CFG_IDX_W-1:0]  index,
  input  logic [fwpi_pkg::CFG_DATA_W-1:0] data,
  output fwpi_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_rl <= fwpi_pkg::RST_KP_RL;
      cfg.kp_rr <= fwpi_pkg::RST_KP_RR;
      cfg.kp_fl <= fwpi_pkg::RST_KP_FL;
      cfg.kp_fr <= fwpi_pkg::RST_KP_FR;
      cfg.ki    <= fwpi_pkg::RST_KI;
      cfg.kd_rl <= fwpi_pkg::RST_KD_RL;
      cfg.ilim  <= fwpi_pkg::RST_ILIM;
      cfg.plim  <= fwpi_pkg::RST_PLIM;
    end else if (wr) begin
      case (index)
        fwpi_pkg::REG_KP_RL: cfg.kp_rl <= data;
        fwpi_pkg::REG_KP_RR: cfg.kp_rr <= data;
        fwpi_pkg::REG_KP_FL: cfg.kp_fl <= data;
        fwpi_pkg::REG_KP_FR: cfg.kp_fr <= data;
        fwpi_pkg::REG_KI:    cfg.ki    <= data;
        fwpi_pkg::REG_KD_RL: cfg.kd_rl <= data;
        fwpi_pkg::REG_ILIM:  cfg.ilim  <= data[14:0];
        fwpi_pkg::REG_PLIM:  cfg.plim  <= data[14:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/fwpi_lane.sv
// one wheel's pi datapath: error, integrator with clamp, derivative, drive sum, truncate and clamp
module fwpi_lane (
  input  logic                   clk,
  input  logic                   rst,
  input  fwpi_pkg::lane_ctrl_t   ctrl,
  input  logic [2:0]             err_mult,
  input  logic [15:0]            kp,
  input  logic [15:0]            kd,
  input  logic [15:0]            ki,
  input  logic [14:0]            ilim,
  input  logic [14:0]            plim,
  input  logic signed [15:0]     target,
  input  logic signed [15:0]     enc,
  output logic signed [15:0]     drive
);

  // stage a: captured request
  logic signed [15:0] tgt_a;
  logic signed [15:0] enc_a;
  // stage b
  logic signed [16:0] err_b;
  logic signed [19:0] pin_b;
  logic signed [33:0] kip_b;
  // stage c
  logic signed [31:0] acc_c;
  logic signed [36:0] pprod_c;
  logic signed [34:0] dprod_c;
  // stage d
  logic signed [47:0] q_d;
  // loop state
  logic signed [31:0] integ;
  logic signed [16:0] prev_err;

  logic signed [16:0] err;
  logic signed [19:0] err_w;
  logic signed [19:0] m_err;
  logic signed [19:0] pin;
  logic signed [33:0] kip;
  logic signed [34:0] isum;
  logic signed [34:0] ilim_w;
  logic signed [31:0] iclamp;
  logic signed [36:0] pprod;
  logic signed [17:0] diff;
  logic signed [34:0] dprod;
  logic signed [47:0] q_next;
  logic signed [31:0] q_int;
  logic signed [31:0] q_tz;
  logic signed [31:0] plim_w;
  logic signed [31:0] drv;

  always_comb begin
    err   = $signed({tgt_a[15], tgt_a}) - $signed({enc_a[15], enc_a});
    err_w = {{3{err[16]}}, err};
    // small constant multiplier as shift and add
    m_err = (err_mult[2] ? (err_w <<< 2) : 20'sd0)
          + (err_mult[1] ? (err_w <<< 1) : 20'sd0)
          + (err_mult[0] ? err_w : 20'sd0);
    pin   = $signed({{4{tgt_a[15]}}, tgt_a}) + m_err;
    kip   = $signed({1'b0, ki}) * err;
  end

  always_comb begin
    isum   = $signed({{3{integ[31]}}, integ}) + $signed({kip_b[33], kip_b});
    ilim_w = $signed({4'b0, ilim, 16'b0});
    if (isum > ilim_w) begin
      iclamp = ilim_w[31:0];
    end else if (isum < -ilim_w) begin
      iclamp = -ilim_w[31:0];
    end else begin
      iclamp = isum[31:0];
    end
    pprod = $signed({1'b0, kp}) * pin_b;
    diff  = $signed({err_b[16], err_b}) - $signed({prev_err[16], prev_err});
    dprod = $signed({1'b0, kd}) * diff;
  end

  always_comb begin
    q_next = $signed({{3{pprod_c[36]}}, pprod_c, 8'b0})
           + $signed({{5{dprod_c[34]}}, dprod_c, 8'b0})
           + $signed({{16{acc_c[31]}}, acc_c});
  end

  // truncate toward zero, then clamp to the pwm limit
  always_comb begin
    q_int  = q_d[47:16];
    q_tz   = q_int + $signed({31'b0, (q_d[47] && (q_d[15:0] != 16'd0))});
    plim_w = $signed({17'b0, plim});
    if (q_tz > plim_w) begin
      drv = plim_w;
    end else if (q_tz < -plim_w) begin
      drv = -plim_w;
    end else begin
      drv = q_tz;
    end
    drive = drv[15:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_a) begin
      tgt_a <= target;
      enc_a <= enc;
    end
    if (ctrl.ld_b) begin
      err_b <= err;
      pin_b <= pin;
      kip_b <= kip;
    end
    if (ctrl.ld_c) begin
      acc_c   <= iclamp;
      pprod_c <= pprod;
      dprod_c <= dprod;
    end
    if (ctrl.ld_d) begin
      q_d <= q_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ    <= '0;
      prev_err <= '0;
    end else if (ctrl.upd) begin
      integ    <= iclamp;
      prev_err <= err_b;
    end
  end

endmodule

FILE: tb/four_wheel_pi_speed_control_core_tb.sv
// testbench for the four-wheel pi speed controller core: directed and random ticks checked against a predictor
`timescale 1ns / 1ps

module four_wheel_pi_speed_control_core_tb;
  import fwpi_pkg::*;

  // wheel order follows the lanes: rear left, rear right, front left, front right
  localparam int FIRST_FRONT = 2;
  localparam longint ERR_WEIGHT [NUM_LANES] = '{5, 4, 3, 2};
  localparam logic signed [15:0] S_MAX = 16'sh7FFF;
  localparam logic signed [15:0] S_MIN = 16'sh8000;

  // one control tick request
  typedef struct {
    logic run;
    logic signed [15:0] target [NUM_LANES];
    logic signed [15:0] enc [NUM_LANES];
  } tick_t;

  // duty and direction for all four wheels
  typedef struct {
    logic [14:0] duty [NUM_LANES];
    logic dir [NUM_LANES];
  } drive_t;

  // receiver stall behavior, picked at random for each stretch
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  // drive predictor and expected-result queue
  class drive_scoreboard;
    logic [15:0] kp [NUM_LANES];
    logic [15:0] ki;
    logic [15:0] kd;
    logic [14:0] ilim;
    logic [14:0] plim;
    longint integ [NUM_LANES];
    longint last_err_rl;
    drive_t expected_drives [$];
    string wheel_name [NUM_LANES] = '{"rear_left", "rear_right", "front_left", "front_right"};
    int errors;
    int results_seen;

    function new();
      kp = '{RST_KP_RL, RST_KP_RR, RST_KP_FL, RST_KP_FR};
      ki = RST_KI;
      kd = RST_KD_RL;
      ilim = RST_ILIM;
      plim = RST_PLIM;
      integ = '{0, 0, 0, 0};
      last_err_rl = 0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_KP_RL: kp[0] = data;
        REG_KP_RR: kp[1] = data;
        REG_KP_FL: kp[2] = data;
        REG_KP_FR: kp[3] = data;
        REG_KI:    ki = data;
        REG_KD_RL: kd = data;
        REG_ILIM:  ilim = data[14:0];
        REG_PLIM:  plim = data[14:0];
        default: ;
      endcase
    endfunction

    // one tick of all four wheel loops; running ticks advance the integrators and last error
    function drive_t compute_drive(tick_t t);
      drive_t r;
      longint err;
      longint acc;
      longint lim;
      longint q16;
      longint drv;
      bit front;
      for (int w = 0; w < NUM_LANES; w++) begin
        front = (w >= FIRST_FRONT);
        drv = 0;
        if (t.run) begin
          err = longint'(t.target[w]) - longint'(t.enc[w]);
          lim = longint'(ilim) * 65536;
          acc = integ[w] + longint'(ki) * err;
          if (acc > lim) acc = lim;
          else if (acc < -lim) acc = -lim;
          integ[w] = acc;
          q16 = longint'(kp[w]) * (longint'(t.target[w]) + ERR_WEIGHT[w] * err) * 256 + acc;
          if (w == LANE_RL) begin
            q16 += longint'(kd) * (err - last_err_rl) * 256;
            last_err_rl = err;
          end
          drv = q16 / 65536;
          if (drv > longint'(plim)) drv = longint'(plim);
          else if (drv < -longint'(plim)) drv = -longint'(plim);
        end
        if (drv > 0) begin
          r.duty[w] = drv[14:0];
          r.dir[w] = front;
        end else begin
          r.duty[w] = 15'(-drv);
          r.dir[w] = !front;
        end
      end
      return r;
    endfunction

    function void note_request(tick_t t);
      expected_drives.push_back(compute_drive(t));
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("mismatch at result %0d: %s", results_seen, msg);
    endfunction

    function void check_result(drive_t got);
      drive_t want;
      results_seen++;
      if (expected_drives.size() == 0) begin
        report("result with no request waiting");
        return;
      end
      want = expected_drives.pop_front();
      for (int w = 0; w < NUM_LANES; w++) begin
        if (got.duty[w] !== want.duty[w])
          report($sformatf("duty_%s expected %0d got %0d", wheel_name[w], want.duty[w],
                           got.duty[w]));
        if (got.dir[w] !== want.dir[w])
          report($sformatf("dir_%s expected %0d got %0d", wheel_name[w], want.dir[w],
                           got.dir[w]));
      end
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction

    function void flush_leftover();
      if (expected_drives.size() != 0) begin
        errors += expected_drives.size();
        $display("%0d expected results never arrived", expected_drives.size());
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  logic in_valid;
  logic in_stall;
  logic run;
  logic signed [15:0] target_rear_left;
  logic signed [15:0] target_rear_right;
  logic signed [15:0] target_front_left;
  logic signed [15:0] target_front_right;
  logic signed [15:0] enc_rear_left;
  logic signed [15:0] enc_rear_right;
  logic signed [15:0] enc_front_left;
  logic signed [15:0] enc_front_right;

  logic out_valid;
  logic out_stall = 1'b0;
  logic [14:0] duty_rear_left;
  logic dir_rear_left;
  logic [14:0] duty_rear_right;
  logic dir_rear_right;
  logic [14:0] duty_front_left;
  logic dir_front_left;
  logic [14:0] duty_front_right;
  logic dir_front_right;

  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  drive_scoreboard sb;

  stall_mode_t stall_mode = STALL_NONE;
  int unsigned stall_left = 0;

  four_wheel_pi_speed_control_core dut (.*);

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stall pattern: stretches of no stall, light, heavy and periodic stalling
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_left[2:0] < 3'd3);
    endcase
  end

  function automatic tick_t mk(logic r,
                               logic signed [15:0] t0, logic signed [15:0] t1,
                               logic signed [15:0] t2, logic signed [15:0] t3,
                               logic signed [15:0] e0, logic signed [15:0] e1,
                               logic signed [15:0] e2, logic signed [15:0] e3);
    tick_t t;
    t.run = r;
    t.target = '{t0, t1, t2, t3};
    t.enc = '{e0, e1, e2, e3};
    return t;
  endfunction

  // handshakes are settled by the falling edge and taken at the next rising edge,
  // so sampling here never races the drivers
  always @(negedge clk) begin : handshake_monitor
    tick_t taken;
    drive_t shown;
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        taken = mk(run, target_rear_left, target_rear_right, target_front_left,
                   target_front_right, enc_rear_left, enc_rear_right, enc_front_left,
                   enc_front_right);
        sb.note_request(taken);
      end
      if (out_valid && !out_stall) begin
        shown.duty = '{duty_rear_left, duty_rear_right, duty_front_left, duty_front_right};
        shown.dir = '{dir_rear_left, dir_rear_right, dir_front_left, dir_front_right};
        sb.check_result(shown);
      end
    end
  end

  // present one request and hold it until taken; in_valid stays high on return
  task automatic send_tick(input tick_t t);
    in_valid <= 1'b1;
    run <= t.run;
    target_rear_left <= t.target[0];
    target_rear_right <= t.target[1];
    target_front_left <= t.target[2];
    target_front_right <= t.target[3];
    enc_rear_left <= t.enc[0];
    enc_rear_right <= t.enc[1];
    enc_front_left <= t.enc[2];
    enc_front_right <= t.enc[3];
    @(negedge clk);
    while (in_stall) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  // one register write; cfg_valid stays high on return
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  // every register once, junk in the unused top bit of the limits, optionally a write
  // to an index past the last register that must be ignored
  task automatic apply_config(input cfg_t c, input bit stray);
    write_cfg(REG_KP_RL, c.kp_rl);
    write_cfg(REG_KP_RR, c.kp_rr);
    write_cfg(REG_KP_FL, c.kp_fl);
    write_cfg(REG_KP_FR, c.kp_fr);
    write_cfg(REG_KI, c.ki);
    write_cfg(REG_KD_RL, c.kd_rl);
    write_cfg(REG_ILIM, {1'($urandom_range(0, 1)), c.ilim});
    write_cfg(REG_PLIM, {1'($urandom_range(0, 1)), c.plim});
    if (stray)
      write_cfg(CFG_IDX_W'($urandom_range(int'(REG_PLIM) + 1, 255)), 16'($urandom()));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending and wait for every expected result
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // mostly a wheel tracking its target closely, some full-range noise
  function automatic tick_t rand_tick();
    tick_t t;
    int style;
    style = $urandom_range(0, 9);
    t.run = ($urandom_range(0, 9) != 0);
    for (int w = 0; w < NUM_LANES; w++) begin
      if (style < 7) begin
        t.target[w] = 16'($urandom_range(0, 600)) - 16'sd300;
        t.enc[w] = t.target[w] + 16'($urandom_range(0, 80)) - 16'sd40;
      end else if (style < 9) begin
        t.target[w] = 16'($urandom());
        t.enc[w] = 16'($urandom());
      end else begin
        t.target[w] = 16'($urandom());
        t.enc[w] = t.target[w];
      end
    end
    return t;
  endfunction

  // style 0: plausible tuning, 1: anything, 2: every register at an extreme
  function automatic cfg_t rand_cfg(input int style);
    cfg_t c;
    if (style == 0) begin
      c.kp_rl = 16'($urandom_range(0, 2048));
      c.kp_rr = 16'($urandom_range(0, 2048));
      c.kp_fl = 16'($urandom_range(0, 2048));
      c.kp_fr = 16'($urandom_range(0, 2048));
      c.ki = 16'($urandom_range(0, 8000));
      c.kd_rl = 16'($urandom_range(0, 1024));
      c.ilim = 15'($urandom_range(0, 4000));
      c.plim = 15'($urandom_range(500, 32767));
    end else if (style == 1) begin
      c = cfg_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    end else begin
      c.kp_rl = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      c.kp_rr = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      c.kp_fl = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      c.kp_fr = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      c.ki = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      c.kd_rl = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      c.ilim = $urandom_range(0, 1) ? 15'h7FFF : 15'h0000;
      c.plim = $urandom_range(0, 1) ? 15'h7FFF : 15'h0000;
    end
    return c;
  endfunction

  // bursts of requests with random gaps, now and then a full drain
  task automatic run_random_phase(input int n_items);
    int sent;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < n_items; k++) begin
        send_tick(rand_tick());
        sent++;
      end
      if ($urandom_range(0, 39) == 0) begin
        wait_for_drain();
      end else if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  // run limit, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    run = 1'b0;
    target_rear_left = '0;
    target_rear_right = '0;
    target_front_left = '0;
    target_front_right = '0;
    enc_rear_left = '0;
    enc_rear_right = '0;
    enc_front_left = '0;
    enc_front_right = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset tuning: run clear, zero drive, full-scale errors both ways, mixed signs
    send_tick(mk(1'b0, S_MAX, S_MIN, 16'sd100, -16'sd100, S_MIN, S_MAX, 16'sd7, -16'sd7));
    send_tick(mk(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_tick(mk(1'b1, S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, S_MIN));
    send_tick(mk(1'b1, S_MIN, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX, S_MAX));
    send_tick(mk(1'b1, 16'sd100, -16'sd100, 16'sd50, -16'sd50,
                 16'sd90, -16'sd80, 16'sd60, -16'sd40));
    send_tick(mk(1'b1, 16'sd10, 16'sd10, 16'sd10, 16'sd10,
                 16'sd10, 16'sd10, 16'sd10, 16'sd10));
    // run clear with integrators loaded: duties zero, state held for the next tick
    send_tick(mk(1'b0, S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, S_MIN));
    send_tick(mk(1'b1, -16'sd1, 16'sd1, -16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    wait_for_drain();

    // derivative term on the rear left wheel: error steps up, down, and reverses
    apply_config('{RST_KP_RL, RST_KP_RR, RST_KP_FL, RST_KP_FR, RST_KI, 16'd256,
                   RST_ILIM, RST_PLIM}, 1'b0);
    send_tick(mk(1'b1, 16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_tick(mk(1'b1, 16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd150, 16'sd0, 16'sd0, 16'sd0));
    send_tick(mk(1'b1, -16'sd300, 16'sd5, -16'sd5, 16'sd5,
                 16'sd200, 16'sd0, 16'sd0, 16'sd0));
    wait_for_drain();

    // both limits zero: integrators pinned at zero, every duty zero
    apply_config('{16'd2000, 16'd2000, 16'd2000, 16'd2000, 16'd40000, 16'd512,
                   15'd0, 15'd0}, 1'b0);
    send_tick(mk(1'b1, S_MAX, S_MIN, 16'sd300, -16'sd300, S_MIN, S_MAX, 16'sd0, 16'sd0));
    send_tick(mk(1'b1, 16'sd1, -16'sd1, S_MAX, S_MIN, 16'sd0, 16'sd0, S_MIN, S_MAX));
    send_tick(mk(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    wait_for_drain();

    // every register at its maximum, plus an ignored write past the register map
    apply_config('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   15'h7FFF, 15'h7FFF}, 1'b1);
    send_tick(mk(1'b1, S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, S_MIN));
    send_tick(mk(1'b1, S_MIN, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX, S_MAX));
    send_tick(mk(1'b1, S_MAX, S_MIN, S_MAX, S_MIN, S_MIN, S_MAX, S_MIN, S_MAX));
    send_tick(mk(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, S_MAX, S_MAX, S_MAX, S_MAX));
    wait_for_drain();

    // all gains zero: drive is the held integral alone
    apply_config('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 15'h7FFF, 15'h7FFF}, 1'b1);
    send_tick(mk(1'b1, S_MAX, S_MIN, 16'sd3, -16'sd3, S_MIN, S_MAX, 16'sd0, 16'sd0));
    send_tick(mk(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_tick(mk(1'b0, 16'sd9, 16'sd9, 16'sd9, 16'sd9, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    wait_for_drain();

    // random phases, each behind a full drain and a fresh set of registers
    for (int p = 0; p < 6; p++) begin
      apply_config(rand_cfg(p % 3), 1'b1);
      run_random_phase(155);
      wait_for_drain();
    end

    // let any stray result surface before the verdict
    repeat (10) @(posedge clk);
    sb.flush_leftover();
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
rtl/fwpi_pkg.sv
rtl/fwpi_cfg_regs.sv
rtl/fwpi_lane.sv
rtl/four_wheel_pi_speed_control_core.sv
tb/four_wheel_pi_speed_control_core_tb.sv
